FILE: rtl/ppidc_pkg.sv
// shared types, register codes and reset values for the positional pid core
package ppidc_pkg;

	localparam int GAIN_W = 20;
	localparam int ILIM_W = 16;
	localparam int OLIM_W = 15;
	localparam int POS_W = 16;
	localparam int DRV_W = 16;
	localparam int ERR_W = 17;
	localparam int STATE_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;
	localparam int FRAC_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ILIM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OLIM = 3'd4;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = 20'd144179;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 20'd852;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 20'd3277;
	localparam logic [ILIM_W-1:0] ILIM_RST = 16'd1000;
	localparam logic [OLIM_W-1:0] OLIM_RST = 15'd2500;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [ILIM_W-1:0] integral_limit;
		logic [OLIM_W-1:0] output_limit;
	} cfg_t;

endpackage

FILE: rtl/position_pid_with_integral_clamp_core.sv
// top level of the positional pid core: five-stage datapath with integral clamp
// One item is accepted per clock while the result side does not stall; its result
// passes the stages in order (error, integral update, products, sum, truncate and
// clamp) into the output register. The feedback paths, the integral add-and-clamp
// and the previous error for the derivative, both close within the second stage,
// so items can follow each other on every clock while the output is not stalled.
// Stalls on the result side are absorbed stage by stage, so empty stages keep
// taking items while a result waits. Registers are written by index through
// the configuration channel, which is always ready; writes to unused indexes
// are dropped. Gains are unsigned Q4.16, the output is truncated toward zero.
module position_pid_with_integral_clamp_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [ppidc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ppidc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [ppidc_pkg::POS_W-1:0]      measured_position,
	input  logic signed [ppidc_pkg::POS_W-1:0]      setpoint,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [ppidc_pkg::DRV_W-1:0]      drive,
	output logic                                    drive_saturated
);
	import ppidc_pkg::*;

	localparam int PROD_W = GAIN_W + 1 + STATE_W;
	localparam int ACC_W = PROD_W + 1;
	localparam int WHOLE_W = ACC_W - FRAC_W;

	cfg_t cfg;

	logic v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;

	logic signed [ERR_W-1:0] err_s1;
	logic signed [STATE_W-1:0] sum_q, prev_q;
	logic signed [STATE_W-1:0] err_s2, sum_s2, diff_s2;
	logic signed [PROD_W-1:0] pp_s3, pi_s3, pd_s3;
	logic signed [ACC_W-1:0] acc_s4;
	logic signed [DRV_W-1:0] drive_q;
	logic sat_q;

	logic signed [ERR_W-1:0] err_in;
	logic signed [STATE_W:0] sum_raw, ilim_w;
	logic signed [STATE_W-1:0] err_ext, sum_next, diff_next;
	logic signed [GAIN_W:0] gp, gi, gd;
	logic signed [WHOLE_W-1:0] whole, olim_w;
	logic round_up;
	logic signed [DRV_W-1:0] olim16, nolim16, drive_next;
	logic sat_next;

	ppidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_valid),
		.wr_index(cfg_index),
		.wr_data (cfg_data),
		.cfg     (cfg)
	);

	assign cfg_ready = 1'b1;

	// per-stage flow control, bubbles collapse under a stalled output
	assign rdy_o = !out_valid_q || out_ready;
	assign rdy4 = !v_s4 || rdy_o;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy_o) out_valid_q <= v_s4;
		end
	end

	// stage 1: position error
	assign err_in = ERR_W'(setpoint) - ERR_W'(measured_position);

	always_ff @(posedge clk) begin
		if (rdy1) err_s1 <= err_in;
	end

	// stage 2: integral add and clamp, derivative difference
	assign err_ext = STATE_W'(err_s1);
	assign sum_raw = (STATE_W+1)'(sum_q) + (STATE_W+1)'(err_s1);
	assign ilim_w = signed'({3'b000, cfg.integral_limit});
	assign diff_next = err_ext - prev_q;

	always_comb begin
		priority if (sum_raw > ilim_w) begin
			sum_next = STATE_W'(ilim_w);
		end else if (sum_raw < -ilim_w) begin
			sum_next = STATE_W'(-ilim_w);
		end else begin
			sum_next = STATE_W'(sum_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			prev_q <= '0;
		end else if (v_s1 && rdy2) begin
			sum_q <= sum_next;
			prev_q <= err_ext;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			err_s2 <= err_ext;
			sum_s2 <= sum_next;
			diff_s2 <= diff_next;
		end
	end

	// stage 3: gain products
	assign gp = signed'({1'b0, cfg.gain_p});
	assign gi = signed'({1'b0, cfg.gain_i});
	assign gd = signed'({1'b0, cfg.gain_d});

	always_ff @(posedge clk) begin
		if (rdy3) begin
			pp_s3 <= PROD_W'(gp) * PROD_W'(err_s2);
			pi_s3 <= PROD_W'(gi) * PROD_W'(sum_s2);
			pd_s3 <= PROD_W'(gd) * PROD_W'(diff_s2);
		end
	end

	// stage 4: sum of terms
	always_ff @(posedge clk) begin
		if (rdy4) acc_s4 <= ACC_W'(pp_s3) + ACC_W'(pi_s3) + ACC_W'(pd_s3);
	end

	// stage 5: truncate toward zero and clamp
	assign round_up = acc_s4[ACC_W-1] && (acc_s4[FRAC_W-1:0] != '0);
	assign whole = signed'(acc_s4[ACC_W-1:FRAC_W] + {{(WHOLE_W-1){1'b0}}, round_up});
	assign olim_w = signed'({{(WHOLE_W-OLIM_W){1'b0}}, cfg.output_limit});
	assign olim16 = signed'({1'b0, cfg.output_limit});
	assign nolim16 = -olim16;

	always_comb begin
		priority if (whole > olim_w) begin
			drive_next = olim16;
			sat_next = 1'b1;
		end else if (whole < -olim_w) begin
			drive_next = nolim16;
			sat_next = 1'b1;
		end else begin
			drive_next = whole[DRV_W-1:0];
			sat_next = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			drive_q <= drive_next;
			sat_q <= sat_next;
		end
	end

	assign out_valid = out_valid_q;
	assign drive = drive_q;
	assign drive_saturated = sat_q;

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && sat_q |-> (drive_q == olim16 || drive_q == nolim16))
		else $error("saturated item not at output limit");

	a_unsat_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !sat_q |-> (drive_q <= olim16 && drive_q >= nolim16))
		else $error("unsaturated item outside output limit");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1 && rdy2) |=> ($stable(sum_q) && $stable(prev_q)))
		else $error("controller state changed without an item");

	a_integral_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> ((STATE_W+1)'(sum_s2) <= ilim_w && (STATE_W+1)'(sum_s2) >= -ilim_w))
		else $error("integral outside its limit");

endmodule

FILE: rtl/ppidc_regs.sv
// configuration register bank for the positional pid core
module ppidc_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [ppidc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [ppidc_pkg::CFG_DATA_W-1:0]    wr_data,
	output ppidc_pkg::cfg_t                     cfg
);
	import ppidc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p <= GAIN_P_RST;
			cfg_q.gain_i <= GAIN_I_RST;
			cfg_q.gain_d <= GAIN_D_RST;
			cfg_q.integral_limit <= ILIM_RST;
			cfg_q.output_limit <= OLIM_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_GAIN_P: cfg_q.gain_p <= wr_data[GAIN_W-1:0];
				REG_GAIN_I: cfg_q.gain_i <= wr_data[GAIN_W-1:0];
				REG_GAIN_D: cfg_q.gain_d <= wr_data[GAIN_W-1:0];
				REG_ILIM: cfg_q.integral_limit <= wr_data[ILIM_W-1:0];
				REG_OLIM: cfg_q.output_limit <= wr_data[OLIM_W-1:0];
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
